// ===== hdl/efrg_pkg.sv =====
// ============================================================================
// efrg_pkg
// shared widths, codes, beat types and control structs of the fade ramp engine
// ============================================================================
package efrg_pkg;

    // core sizing
    localparam int TIMER_BITS = 24;
    localparam int FRAC_BITS  = 16;

    // beat field widths
    localparam int CMD_W     = 3;
    localparam int ELAPSED_W = 16;
    localparam int LEN_W     = 24;
    localparam int CURVE_W   = 3;
    localparam int PROG_W    = FRAC_BITS + 1;
    localparam int PHASE_W   = 2;

    // derived datapath widths
    localparam int STEP_W   = $clog2(FRAC_BITS);
    localparam int PROD_W   = 2 * PROG_W;
    localparam int SCALED_W = PROD_W + 3;
    localparam int SUM_W    = ((TIMER_BITS > ELAPSED_W) ? TIMER_BITS : ELAPSED_W) + 1;
    localparam int CMP_W    = (LEN_W > TIMER_BITS) ? LEN_W : TIMER_BITS;

    localparam logic [PROG_W-1:0] ONE_Q  = PROG_W'(1) << FRAC_BITS;
    localparam logic [PROG_W-1:0] HALF_Q = PROG_W'(1) << (FRAC_BITS - 1);

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK     = 3'd0,
        CMD_FADE_IN  = 3'd1,
        CMD_FADE_OUT = 3'd2,
        CMD_PAUSE    = 3'd3,
        CMD_RESUME   = 3'd4
    } cmd_t;

    typedef enum logic [PHASE_W-1:0] {
        PH_OPEN   = 2'd0,
        PH_IN     = 2'd1,
        PH_OUT    = 2'd2,
        PH_CLOSED = 2'd3
    } phase_t;

    typedef enum logic [CURVE_W-1:0] {
        CURVE_LINEAR      = 3'd0,
        CURVE_IN_QUAD     = 3'd1,
        CURVE_OUT_QUAD    = 3'd2,
        CURVE_INOUT_QUAD  = 3'd3,
        CURVE_IN_CUBIC    = 3'd4,
        CURVE_OUT_CUBIC   = 3'd5,
        CURVE_INOUT_CUBIC = 3'd6
    } curve_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_MUL_SQ,
        ST_MUL_CUBE,
        ST_FINISH,
        ST_WRITE
    } state_t;

    typedef struct packed {
        logic [CMD_W-1:0]     cmd;
        logic [ELAPSED_W-1:0] elapsed_ticks;
        logic [LEN_W-1:0]     fade_length;
        logic [CURVE_W-1:0]   curve_select;
    } in_beat_t;

    typedef struct packed {
        logic [PROG_W-1:0]  progress;
        logic [PHASE_W-1:0] fade_phase;
        logic               is_paused;
    } out_beat_t;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic div_step;
        logic mul_sq;
        logic mul_cube;
        logic finish;
        logic out_load;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic tick_run;
        logic need_mul;
        logic need_cube;
    } dp_status_t;

    // zero length becomes one, too long saturates at the timer range
    function automatic logic [TIMER_BITS-1:0] sat_len(input logic [LEN_W-1:0] len);
        logic [CMP_W-1:0] wide;
        logic [CMP_W-1:0] lim;
        wide = CMP_W'(len);
        lim  = CMP_W'({TIMER_BITS{1'b1}});
        if (wide == '0) begin
            wide = CMP_W'(1);
        end else if (wide > lim) begin
            wide = lim;
        end
        return wide[TIMER_BITS-1:0];
    endfunction

endpackage

// ===== hdl/efrg_ctrl.sv =====
// ============================================================================
// efrg_ctrl
// sequencer: accept, divide steps, multiply steps, finish and result hand-off
// ============================================================================
module efrg_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    output logic                 m_valid,
    input  logic                 m_ready,
    input  efrg_pkg::dp_status_t status,
    output efrg_pkg::dp_cmd_t    cmd
);
    import efrg_pkg::*;

    state_t            state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            step_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        step_next    = step_reg;
        m_valid_next = m_valid_reg && !m_ready;
        s_ready      = 1'b0;
        cmd          = '0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready   = 1'b1;
                step_next = '0;
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    state_next = status.tick_run ? ST_DIV : ST_WRITE;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(FRAC_BITS - 1)) begin
                    state_next = status.need_mul ? ST_MUL_SQ : ST_FINISH;
                end
            end
            ST_MUL_SQ: begin
                cmd.mul_sq = 1'b1;
                state_next = status.need_cube ? ST_MUL_CUBE : ST_FINISH;
            end
            ST_MUL_CUBE: begin
                cmd.mul_cube = 1'b1;
                state_next   = ST_FINISH;
            end
            ST_FINISH: begin
                cmd.finish = 1'b1;
                state_next = ST_WRITE;
            end
            ST_WRITE: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_valid = m_valid_reg;

endmodule

// ===== hdl/efrg_datapath.sv =====
// ============================================================================
// efrg_datapath
// fade state, restoring divider for t, shared multiplier, easing and output
// ============================================================================
module efrg_datapath (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  efrg_pkg::in_beat_t   s_beat,
    input  efrg_pkg::dp_cmd_t    cmd,
    output efrg_pkg::dp_status_t status,
    output efrg_pkg::out_beat_t  m_beat
);
    import efrg_pkg::*;

    // fade state
    phase_t                phase_reg;
    logic [TIMER_BITS-1:0] timer_reg;
    logic [TIMER_BITS-1:0] length_reg;
    logic [CURVE_W-1:0]    curve_reg;
    logic [PROG_W-1:0]     progress_reg;
    logic                  pause_reg;

    // working registers
    logic                  t_hi_reg;
    logic [FRAC_BITS-1:0]  q_lo_reg;
    logic [TIMER_BITS-1:0] rem_reg;
    logic [PROD_W-1:0]     prod_reg;
    out_beat_t             out_reg;

    logic [SUM_W-1:0]      timer_sum;
    logic [TIMER_BITS-1:0] timer_new;
    logic                  timer_full;
    logic                  fading;
    logic [TIMER_BITS:0]   rem_shift;
    logic [TIMER_BITS:0]   rem_sub;
    logic                  div_ge;
    logic [PROG_W-1:0]     t_q;
    logic                  t_low;
    logic                  mirror;
    logic                  need_mul;
    logic                  need_cube;
    logic [1:0]            shamt;
    logic [PROG_W-1:0]     ease_x;
    logic [PROD_W-1:0]     sq_sum;
    logic [PROG_W-1:0]     sq_val;
    logic [PROG_W-1:0]     mul_a;
    logic [PROD_W-1:0]     mul_p;
    logic [SCALED_W-1:0]   scaled;
    logic [PROG_W-1:0]     s_val;
    logic [PROG_W-1:0]     eased;

    // timer add, saturating at the fade length
    assign timer_sum  = SUM_W'(timer_reg) + SUM_W'(s_beat.elapsed_ticks);
    assign timer_full = timer_sum >= SUM_W'(length_reg);
    assign timer_new  = timer_full ? length_reg : timer_sum[TIMER_BITS-1:0];
    assign fading     = (phase_reg == PH_IN) || (phase_reg == PH_OUT);

    // one restoring step per cycle
    assign rem_shift = {rem_reg, 1'b0};
    assign div_ge    = rem_shift >= {1'b0, length_reg};
    assign rem_sub   = rem_shift - {1'b0, length_reg};

    assign t_q   = {t_hi_reg, q_lo_reg};
    assign t_low = !t_hi_reg && !q_lo_reg[FRAC_BITS-1];

    always_comb begin
        mirror    = 1'b0;
        need_mul  = 1'b1;
        need_cube = 1'b0;
        shamt     = 2'd0;
        unique case (curve_reg)
            CURVE_IN_QUAD: begin
            end
            CURVE_OUT_QUAD: begin
                mirror = 1'b1;
            end
            CURVE_INOUT_QUAD: begin
                mirror = !t_low;
                shamt  = 2'd1;
            end
            CURVE_IN_CUBIC: begin
                need_cube = 1'b1;
            end
            CURVE_OUT_CUBIC: begin
                mirror    = 1'b1;
                need_cube = 1'b1;
            end
            CURVE_INOUT_CUBIC: begin
                mirror    = !t_low;
                need_cube = 1'b1;
                shamt     = 2'd2;
            end
            default: begin
                need_mul = 1'b0;
            end
        endcase
    end

    // mirrored curves work on u = one - t
    assign ease_x = mirror ? (ONE_Q - t_q) : t_q;
    assign sq_sum = prod_reg + PROD_W'(HALF_Q);
    assign sq_val = sq_sum[FRAC_BITS +: PROG_W];
    assign mul_a  = cmd.mul_cube ? sq_val : ease_x;
    assign mul_p  = mul_a * ease_x;

    assign scaled = (SCALED_W'(prod_reg) << shamt) + SCALED_W'(HALF_Q);
    assign s_val  = scaled[FRAC_BITS +: PROG_W];
    assign eased  = !need_mul ? t_q : (mirror ? (ONE_Q - s_val) : s_val);

    assign status.tick_run  = (s_beat.cmd == CMD_TICK) && fading && !pause_reg;
    assign status.need_mul  = need_mul;
    assign status.need_cube = need_cube;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_OPEN;
            timer_reg    <= '0;
            length_reg   <= TIMER_BITS'(1);
            curve_reg    <= CURVE_LINEAR;
            progress_reg <= ONE_Q;
            pause_reg    <= 1'b0;
        end else begin
            if (cmd.accept) begin
                unique case (s_beat.cmd)
                    CMD_TICK: begin
                        if (status.tick_run) begin
                            timer_reg <= timer_new;
                        end
                    end
                    CMD_FADE_IN: begin
                        phase_reg    <= PH_IN;
                        progress_reg <= '0;
                        timer_reg    <= '0;
                        length_reg   <= sat_len(s_beat.fade_length);
                        curve_reg    <= s_beat.curve_select;
                    end
                    CMD_FADE_OUT: begin
                        phase_reg    <= PH_OUT;
                        progress_reg <= ONE_Q;
                        timer_reg    <= '0;
                        length_reg   <= sat_len(s_beat.fade_length);
                        curve_reg    <= s_beat.curve_select;
                    end
                    CMD_PAUSE: begin
                        pause_reg <= 1'b1;
                    end
                    CMD_RESUME: begin
                        pause_reg <= 1'b0;
                    end
                    default: begin
                    end
                endcase
            end
            if (cmd.finish) begin
                if (phase_reg == PH_OUT) begin
                    if (t_hi_reg) begin
                        phase_reg    <= PH_CLOSED;
                        progress_reg <= '0;
                    end else begin
                        progress_reg <= ONE_Q - eased;
                    end
                end else begin
                    if (t_hi_reg) begin
                        phase_reg    <= PH_OPEN;
                        progress_reg <= ONE_Q;
                    end else begin
                        progress_reg <= eased;
                    end
                end
            end
        end
    end

    // divider, multiplier and output registers
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            // timer never passes the length, so the integer bit is timer == length
            t_hi_reg <= (timer_new == length_reg);
            q_lo_reg <= '0;
            rem_reg  <= (timer_new == length_reg) ? '0 : timer_new;
        end else if (cmd.div_step) begin
            q_lo_reg <= {q_lo_reg[FRAC_BITS-2:0], div_ge};
            rem_reg  <= div_ge ? rem_sub[TIMER_BITS-1:0] : rem_shift[TIMER_BITS-1:0];
        end
        if (cmd.mul_sq || cmd.mul_cube) begin
            prod_reg <= mul_p;
        end
        if (cmd.out_load) begin
            out_reg.progress   <= progress_reg;
            out_reg.fade_phase <= phase_reg;
            out_reg.is_paused  <= pause_reg;
        end
    end

    assign m_beat = out_reg;

endmodule

// ===== hdl/eased_fade_ramp_generator.sv =====
// ============================================================================
// eased_fade_ramp_generator
// fade ramp engine: timed fade in / fade out with linear, quadratic and cubic
// easing, progress reported in Q1.16 after every command beat
// ============================================================================
//
// channel   | dir | handshake          | beat
// ----------+-----+--------------------+------------------------------------
// s_        | in  | s_valid / s_ready  | cmd, elapsed_ticks, fade_length,
//           |     |                    | curve_select
// m_        | out | m_valid / m_ready  | progress, fade_phase, is_paused
//
// - start, pause, resume, unused codes and ignored ticks go from accept to write
// - a counting tick runs accept, one divide step per quotient bit of the
//   restoring divider (FRAC_BITS), 0 to 2 passes through the shared
//   17x17 multiplier for the easing curve, then finish and write
// - one beat is in flight at a time; s_ready is high only while idle
// - the output register holds a result until taken, so the next beat can be
//   accepted and worked on meanwhile; only the write-back waits on m_ready
// - aresetn (synchronous, active low) gives open idle, fully open progress,
//   linear curve, length one, not paused and no result pending
//
module eased_fade_ramp_generator (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  efrg_pkg::in_beat_t  s_beat,
    output logic                m_valid,
    input  logic                m_ready,
    output efrg_pkg::out_beat_t m_beat
);
    import efrg_pkg::*;

    dp_cmd_t    dp_cmd;
    dp_status_t dp_status;

    // sequencer: owns the handshakes and the step count of the divider
    efrg_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (dp_status),
        .cmd     (dp_cmd)
    );

    // fade state, divider, multiplier and output register
    efrg_datapath u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_beat  (s_beat),
        .cmd     (dp_cmd),
        .status  (dp_status),
        .m_beat  (m_beat)
    );

    // an accepted beat always keeps the engine busy in the cycle after the accept
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted on back-to-back cycles");

    // progress never exceeds fully open
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_beat.progress <= ONE_Q))
        else $error("progress above one");

    // settled phases report their end value
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_beat.fade_phase == PH_CLOSED)) |-> (m_beat.progress == '0))
        else $error("closed phase with nonzero progress");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_beat.fade_phase == PH_OPEN)) |-> (m_beat.progress == ONE_Q))
        else $error("open phase without full progress");

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
// ============================================================================
// tb_top
// self-checking bench for the eased fade ramp generator: directed fades over
// every curve, pause and odd command cases, then random fade sequences under
// three handshake idling mixes, each result beat checked against a local
// fixed-point model of the fade state
// ============================================================================
module tb_top;
    import efrg_pkg::*;

    // fixed-point constants of the model, kept 64 bits wide
    localparam longint unsigned UNITY     = 64'd1 << FRAC_BITS;
    localparam longint unsigned HALF      = UNITY >> 1;
    localparam longint unsigned TIMER_TOP = (64'd1 << TIMER_BITS) - 1;

    // codes with no package name: spare commands and the spare curve
    localparam logic [CMD_W-1:0]   CMD_UNUSED_FIRST = 3'd5;
    localparam logic [CMD_W-1:0]   CMD_UNUSED_LAST  = 3'd7;
    localparam logic [CURVE_W-1:0] CURVE_UNUSED     = 3'd7;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_beat_t  s_beat  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_beat_t m_beat;

    // idling mix, percent of cycles
    int send_gap_pct   = 0;
    int recv_stall_pct = 0;

    // model state of the fade engine
    phase_t          fade_ph;
    longint unsigned fade_timer;
    longint unsigned fade_len;
    logic [2:0]      fade_curve;
    longint unsigned fade_prog;
    logic            fade_paused;
    int              live_items = 0;  // beats that did more than report state

    out_beat_t fade_expect_q[$];
    out_beat_t want_beat;
    int        fail_count = 0;

    eased_fade_ramp_generator dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_beat  (s_beat),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_beat  (m_beat)
    );

    // 8 ns clock
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Q1.16 product, rounded half up
    function automatic longint unsigned qmul(input longint unsigned a,
                                             input longint unsigned b);
        return (a * b + HALF) >> FRAC_BITS;
    endfunction

    // advance the fade model by one command beat and give the beat it reports
    function automatic out_beat_t fade_model_step(input in_beat_t b);
        longint unsigned t;
        longint unsigned u;
        longint unsigned eased;
        longint unsigned len_v;
        out_beat_t       o;
        case (b.cmd)
            CMD_TICK: begin
                // ticks only count while fading and not paused
                if ((fade_ph == PH_IN || fade_ph == PH_OUT) && !fade_paused) begin
                    live_items++;
                    fade_timer += b.elapsed_ticks;
                    if (fade_timer > fade_len) fade_timer = fade_len;
                    t = (fade_timer * UNITY) / fade_len;
                    if (t > UNITY) t = UNITY;
                    u = UNITY - t;
                    case (fade_curve)
                        CURVE_IN_QUAD:   eased = qmul(t, t);
                        CURVE_OUT_QUAD:  eased = UNITY - qmul(u, u);
                        CURVE_INOUT_QUAD: begin
                            if (t < HALF) eased = (2 * t * t + HALF) >> FRAC_BITS;
                            else eased = UNITY - ((2 * u * u + HALF) >> FRAC_BITS);
                        end
                        CURVE_IN_CUBIC:  eased = qmul(qmul(t, t), t);
                        CURVE_OUT_CUBIC: eased = UNITY - qmul(qmul(u, u), u);
                        CURVE_INOUT_CUBIC: begin
                            if (t < HALF) eased = (4 * qmul(t, t) * t + HALF) >> FRAC_BITS;
                            else eased = UNITY - ((4 * qmul(u, u) * u + HALF) >> FRAC_BITS);
                        end
                        default:         eased = t;  // linear and the spare code
                    endcase
                    if (fade_ph == PH_OUT) begin
                        fade_prog = UNITY - eased;
                        if (t >= UNITY) begin
                            fade_ph   = PH_CLOSED;
                            fade_prog = 0;
                        end
                    end else begin
                        fade_prog = eased;
                        if (t >= UNITY) begin
                            fade_ph   = PH_OPEN;
                            fade_prog = UNITY;
                        end
                    end
                end
            end
            CMD_FADE_IN, CMD_FADE_OUT: begin
                live_items++;
                len_v = b.fade_length;
                if (len_v == 0) len_v = 1;
                if (len_v > TIMER_TOP) len_v = TIMER_TOP;
                fade_ph    = (b.cmd == CMD_FADE_IN) ? PH_IN : PH_OUT;
                fade_prog  = (b.cmd == CMD_FADE_IN) ? 0 : UNITY;
                fade_timer = 0;
                fade_len   = len_v;
                fade_curve = b.curve_select;
            end
            CMD_PAUSE: begin
                live_items++;
                fade_paused = 1'b1;
            end
            CMD_RESUME: begin
                live_items++;
                fade_paused = 1'b0;
            end
            default: ;  // spare codes only report
        endcase
        o.progress   = PROG_W'(fade_prog);
        o.fade_phase = fade_ph;
        o.is_paused  = fade_paused;
        return o;
    endfunction

    function automatic in_beat_t mk_beat(input logic [CMD_W-1:0] cmd,
                                         input logic [ELAPSED_W-1:0] elapsed,
                                         input logic [LEN_W-1:0] len,
                                         input logic [CURVE_W-1:0] curve);
        in_beat_t b;
        b.cmd           = cmd;
        b.elapsed_ticks = elapsed;
        b.fade_length   = len;
        b.curve_select  = curve;
        return b;
    endfunction

    // every field random, unused fields included
    function automatic in_beat_t noise_beat();
        return mk_beat(CMD_W'($urandom), ELAPSED_W'($urandom), LEN_W'($urandom),
                       CURVE_W'($urandom));
    endfunction

    // mostly short fades so the ticks finish them, a few long or odd ones
    function automatic logic [LEN_W-1:0] pick_fade_length();
        int r;
        r = $urandom_range(99);
        if (r < 70) return LEN_W'($urandom_range(2000, 1));
        if (r < 88) return LEN_W'($urandom_range(300000, 2001));
        if (r < 96) return LEN_W'($urandom);
        if (r < 98) return '0;
        return '1;
    endfunction

    // tick sizes scaled to the current fade, plus full range and tiny ones
    function automatic logic [ELAPSED_W-1:0] pick_elapsed();
        longint unsigned spread;
        int              r;
        spread = fade_len / 4 + 1;
        if (spread > 65535) spread = 65535;
        r = $urandom_range(99);
        if (r < 60) return ELAPSED_W'($urandom_range(int'(spread), 0));
        if (r < 80) return ELAPSED_W'($urandom);
        return ELAPSED_W'($urandom_range(3, 0));
    endfunction

    // one beat on the input channel; valid is left high after the accept so
    // the next beat can follow back to back, any wait lowers it first
    task automatic send_cmd(input in_beat_t b);
        while ($urandom_range(99) < send_gap_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_beat  <= b;
        do @(posedge aclk); while (!s_ready);
        fade_expect_q.push_back(fade_model_step(b));
    endtask

    // hold off the sender until every result beat is back
    task automatic drain_results();
        s_valid <= 1'b0;
        while (fade_expect_q.size() != 0) @(posedge aclk);
    endtask

    // state after reset is reported by a spare command; ticks in open idle do nothing
    task automatic test_idle_reports();
        send_cmd(mk_beat(CMD_UNUSED_LAST, '1, '1, CURVE_UNUSED));
        send_cmd(mk_beat(CMD_TICK, 16'd100, '0, CURVE_LINEAR));
    endtask

    // zero length is stored as one; zero tick keeps the fade going
    task automatic test_zero_length_fade();
        send_cmd(mk_beat(CMD_FADE_IN, '1, '0, CURVE_LINEAR));
        send_cmd(mk_beat(CMD_TICK, '0, '1, CURVE_LINEAR));
        send_cmd(mk_beat(CMD_TICK, '1, '0, CURVE_LINEAR));
    endtask

    // pause freezes ticks, a start while paused keeps the pause,
    // in-out quad crosses its midpoint exactly
    task automatic test_pause_behavior();
        send_cmd(mk_beat(CMD_FADE_OUT, '0, '1, CURVE_INOUT_CUBIC));
        send_cmd(mk_beat(CMD_TICK, '1, '0, CURVE_LINEAR));
        send_cmd(mk_beat(CMD_PAUSE, '0, '0, CURVE_LINEAR));
        send_cmd(mk_beat(CMD_TICK, 16'd1234, '0, CURVE_LINEAR));
        send_cmd(mk_beat(CMD_FADE_IN, '0, 24'd1000, CURVE_INOUT_QUAD));
        send_cmd(mk_beat(CMD_TICK, 16'd400, '0, CURVE_LINEAR));
        send_cmd(mk_beat(CMD_RESUME, '0, '0, CURVE_LINEAR));
        send_cmd(mk_beat(CMD_TICK, 16'd500, '0, CURVE_LINEAR));
        send_cmd(mk_beat(CMD_TICK, 16'd499, '0, CURVE_LINEAR));
        send_cmd(mk_beat(CMD_TICK, 16'd1, '0, CURVE_LINEAR));
        drain_results();
    endtask

    // spare curve acts as linear; fade out ends closed, ticks then ignored
    task automatic test_spare_codes();
        send_cmd(mk_beat(CMD_FADE_OUT, '0, 24'd3, CURVE_UNUSED));
        send_cmd(mk_beat(CMD_TICK, 16'd1, '0, CURVE_LINEAR));
        send_cmd(mk_beat(CMD_TICK, 16'd5, '0, CURVE_LINEAR));
        send_cmd(mk_beat(CMD_TICK, 16'd2, '0, CURVE_LINEAR));
        send_cmd(mk_beat(CMD_UNUSED_FIRST, '0, '0, CURVE_LINEAR));
    endtask

    // remaining curves, alternating direction
    task automatic test_curve_set();
        logic [CURVE_W-1:0] curves[4];
        curves = '{CURVE_IN_QUAD, CURVE_OUT_QUAD, CURVE_IN_CUBIC, CURVE_OUT_CUBIC};
        foreach (curves[i]) begin
            send_cmd(mk_beat(i % 2 ? CMD_FADE_OUT : CMD_FADE_IN, '0, 24'd7, curves[i]));
            send_cmd(mk_beat(CMD_TICK, 16'd3, '0, CURVE_LINEAR));
        end
    endtask

    // random fades: mostly a start followed by ticks with random content,
    // mixed with pauses, resumes, restarts, spare codes and stray ticks
    task automatic run_random_fades(input int target, input int gap_pct, input int stall_pct);
        int       first_live;
        int       steps;
        int       r;
        in_beat_t b;
        send_gap_pct   = gap_pct;
        recv_stall_pct = stall_pct;
        first_live     = live_items;
        while (live_items - first_live < target) begin
            if ($urandom_range(99) < 92) begin
                b = noise_beat();
                b.cmd          = $urandom_range(1) ? CMD_FADE_IN : CMD_FADE_OUT;
                b.fade_length  = pick_fade_length();
                b.curve_select = CURVE_W'($urandom_range(CURVE_UNUSED));
                send_cmd(b);
            end
            steps = $urandom_range(24, 4);
            for (int i = 0; i < steps; i++) begin
                b = noise_beat();
                r = $urandom_range(99);
                if (fade_paused && r < 50) begin
                    b.cmd = CMD_RESUME;
                end else if (r < 82) begin
                    b.cmd           = CMD_TICK;
                    b.elapsed_ticks = pick_elapsed();
                end else if (r < 87) begin
                    b.cmd = CMD_PAUSE;
                end else if (r < 91) begin
                    b.cmd = CMD_RESUME;
                end else if (r < 96) begin
                    b.cmd = CMD_W'($urandom_range(CMD_UNUSED_LAST, CMD_UNUSED_FIRST));
                end else begin
                    b.cmd         = $urandom_range(1) ? CMD_FADE_IN : CMD_FADE_OUT;
                    b.fade_length = pick_fade_length();
                end
                send_cmd(b);
                // finished fade: usually move on to the next one
                if (!(fade_ph == PH_IN || fade_ph == PH_OUT) && $urandom_range(99) < 70) break;
            end
        end
    endtask

    // result channel: check each accepted beat, then pick the next ready
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (fade_expect_q.size() == 0) begin
                    $error("result beat with nothing expected");
                    fail_count++;
                end else begin
                    want_beat = fade_expect_q.pop_front();
                    if (m_beat.progress !== want_beat.progress) begin
                        $error("progress: expected %0d, got %0d",
                               want_beat.progress, m_beat.progress);
                        fail_count++;
                    end
                    if (m_beat.fade_phase !== want_beat.fade_phase) begin
                        $error("fade_phase: expected %0d, got %0d",
                               want_beat.fade_phase, m_beat.fade_phase);
                        fail_count++;
                    end
                    if (m_beat.is_paused !== want_beat.is_paused) begin
                        $error("is_paused: expected %0d, got %0d",
                               want_beat.is_paused, m_beat.is_paused);
                        fail_count++;
                    end
                end
            end
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial begin
        // model reset: open idle, fully open, linear, length one
        fade_ph     = PH_OPEN;
        fade_timer  = 0;
        fade_len    = 1;
        fade_curve  = CURVE_LINEAR;
        fade_prog   = UNITY;
        fade_paused = 1'b0;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        // directed part, light idling on both sides
        send_gap_pct   = 20;
        recv_stall_pct = 20;
        test_idle_reports();
        test_zero_length_fade();
        test_pause_behavior();
        test_spare_codes();
        test_curve_set();
        drain_results();

        // random part: sender mostly busy, then receiver mostly busy, then no idling
        run_random_fades(340, 6, 61);
        drain_results();
        run_random_fades(340, 61, 6);
        drain_results();
        run_random_fades(340, 0, 0);
        drain_results();

        // extra wait for any stray beat to show up
        repeat (40) @(posedge aclk);
        if (fail_count == 0 && fade_expect_q.size() == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

    // watchdog, far beyond the slowest correct run
    initial begin
        #5_000_000;
        $display("tb_top: FAIL");
        $finish;
    end

endmodule

// ===== eased_fade_ramp_generator.f =====
hdl/efrg_pkg.sv
hdl/efrg_ctrl.sv
hdl/efrg_datapath.sv
hdl/eased_fade_ramp_generator.sv
sim/tb_top.sv
